@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the slot allocator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define RSSA_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("slot allocator assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define RSSA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("slot allocator assertion failed");

`endif

@@ hw/rtl/rssa_pkg.sv @@
// Shared types and constants of the ring scan slot allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rssa_pkg;

    // Fixed field widths.
    localparam int ADDR_W     = 48;
    localparam int STRIDE_W   = 13;
    localparam int COUNT_W    = 9;
    localparam int SLOT_OUT_W = 8;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;

    // The used map is stored as rows of this many slots.
    localparam int ROW_W  = 32;
    localparam int ROW_BW = 5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DOUBLE = 2'd3;

    // Request codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd2;

    // Configuration reset values.
    localparam logic [COUNT_W-1:0]  RST_SLOTS  = 9'd256;
    localparam logic [STRIDE_W-1:0] RST_STRIDE = 13'd32;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_CHK,
        S_A_MUL,
        S_A_ADD,
        S_F_SUB,
        S_F_CMP,
        S_F_DIV,
        S_F_RD,
        S_F_CHK,
        S_DONE
    } t_state;

    // Status of the divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

@@ hw/rtl/rssa_map.sv @@
// Row-organized storage for the used-slot bitmap.
// Depends on rssa_pkg for the row width.
`timescale 1ns / 1ps
`default_nettype none

module rssa_map import rssa_pkg::*; #(
    parameter int ROWS = 8,
    parameter int AW   = 3
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [ROW_W-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [ROW_W-1:0] o_rdata
);

    logic [ROW_W-1:0] r_mem [ROWS];
    logic [ROW_W-1:0] r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/rssa_div.sv @@
// Restoring divider that yields one quotient bit per cycle.
// Depends on rssa_pkg for the divider status struct.
`timescale 1ns / 1ps
`default_nettype none

module rssa_div import rssa_pkg::*; #(
    parameter int QW = 8,
    parameter int VW = 13
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [QW+VW-1:0] i_dividend,
    input  wire logic [VW-1:0]    i_divisor,
    output logic      [QW-1:0]    o_quotient,
    output t_div_stat             o_stat
);

    localparam int DW = QW + VW;
    localparam int CW = $clog2(QW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [QW-1:0] r_quo;
    logic          ge;

    assign ge = (r_rem >= r_div);

    // Iteration control: the caller guarantees the quotient fits in QW bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // One trial subtraction per cycle, divisor walks down one bit at a time.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_div <= DW'(i_divisor) << (QW - 1);
            r_quo <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_div;
            end
            r_quo <= {r_quo[QW-2:0], ge};
            r_div <= r_div >> 1;
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

@@ hw/rtl/ring_scan_slot_allocator.sv @@
// Next-fit slot allocator over a bitmap of used slots.
//
// Input channel (i_in_valid / o_in_stall) carries one request beat: i_cmd selects
// allocate or free, i_free_address names the slot to free. Output channel
// (o_out_valid / i_out_stall) carries one result beat per request: status, slot
// address and slot number. Configuration registers are written through
// i_cfg_we / i_cfg_index / i_cfg_data; the user must write them only while no
// request is in flight, which the block itself does not enforce. One request is
// worked on at a time; o_in_stall is high from acceptance until the result enters
// the output register. The output register holds a finished result while the
// receiver stalls, and the next request is taken meanwhile. An allocate scans one
// 32-slot row at a time, reading it and then checking it; with no slots managed
// it goes straight to the result. A free runs the restoring divider, one quotient
// bit per cycle; a zero stride skips the divider, as does an address rejected
// before dividing.
// After reset the map is cleared one row per cycle, with requests stalled;
// configuration writes are taken throughout. Reset returns head to slot zero
// and the registers to 256 slots, base zero and stride 32.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ring_scan_slot_allocator import rssa_pkg::*; #(
    parameter int MAX_SLOTS = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Request channel.
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_cmd,
    input  wire logic [ADDR_W-1:0]     i_free_address,
    // Result channel.
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic      [STATUS_W-1:0]   o_status,
    output logic      [ADDR_W-1:0]     o_slot_address,
    output logic      [SLOT_OUT_W-1:0] o_slot_number,
    // Configuration write port.
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ADDR_W-1:0]     i_cfg_data
);

    localparam int ROWS = (MAX_SLOTS + ROW_W - 1) / ROW_W;
    localparam int RIW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int XW   = RIW + ROW_BW;
    localparam int NW   = XW + 1;
    localparam int CMPW = (NW > COUNT_W) ? NW : COUNT_W;
    localparam int PW   = NW + STRIDE_W;
    localparam int DW   = XW + STRIDE_W;
    localparam int EW   = XW + SLOT_OUT_W;

    t_state r_state;
    t_state n_state;

    // Configuration.
    logic [COUNT_W-1:0]  r_slots_in_use;
    logic [ADDR_W-1:0]   r_base_address;
    logic [STRIDE_W-1:0] r_slot_stride;

    // Control state.
    logic [RIW-1:0] r_row;
    logic           r_pass;
    logic [XW-1:0]  r_head;
    logic           r_out_valid;

    // Working payload.
    logic [ADDR_W-1:0]   r_addr;
    logic [XW-1:0]       r_start;
    logic [NW-1:0]       r_lo;
    logic [NW-1:0]       r_hi;
    logic [XW-1:0]       r_slot;
    logic [PW-1:0]       r_prod;
    logic [ADDR_W-1:0]   r_offset;
    logic                r_below;
    logic [STATUS_W-1:0] r_res_status;
    logic [ADDR_W-1:0]   r_res_addr;
    logic [XW-1:0]       r_res_slot;
    logic [STATUS_W-1:0] r_out_status;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [SLOT_OUT_W-1:0] r_out_slot;

    // Combinational helpers.
    logic              in_acc;
    logic              out_load;
    logic [NW-1:0]     n_cnt;
    logic [XW-1:0]     start_slot;
    logic [NW-1:0]     hm1;
    logic [RIW-1:0]    last_row;
    logic [ROW_W-1:0]  free_bits;
    logic              found;
    logic [ROW_BW-1:0] ffs;
    logic [XW-1:0]     found_slot;
    logic [NW-1:0]     s_plus1;
    logic [XW-1:0]     next_head;
    logic [NW-1:0]     mul_a;
    logic [PW-1:0]     mul_prod;
    logic [ADDR_W:0]   sub_res;
    logic [EW-1:0]     slot_ext;
    logic              slot_bit;

    // Map and divider connections.
    logic             map_we;
    logic [ROW_W-1:0] map_wdata;
    logic [ROW_W-1:0] map_rdata;
    logic             div_start;
    logic [XW-1:0]    div_quo;
    t_div_stat        div_stat;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // Number of slots actually managed.
    assign n_cnt = (CMPW'(r_slots_in_use) > CMPW'(MAX_SLOTS)) ? NW'(MAX_SLOTS)
                                                              : NW'(r_slots_in_use);
    assign start_slot = (NW'(r_head) < n_cnt) ? r_head : '0;

    // Last row of the current scan pass.
    assign hm1      = r_hi - NW'(1);
    assign last_row = hm1[XW-1:ROW_BW];

    // Free slots of the row just read, limited to the pass window [lo, hi).
    always_comb begin
        logic [NW-1:0] slot_b;
        free_bits = '0;
        ffs       = '0;
        for (int b = 0; b < ROW_W; b++) begin
            slot_b       = NW'({r_row, ROW_BW'(b)});
            free_bits[b] = !map_rdata[b] && (slot_b >= r_lo) && (slot_b < r_hi);
        end
        for (int b = ROW_W - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                ffs = ROW_BW'(b);
            end
        end
    end

    assign found      = |free_bits;
    assign found_slot = {r_row, ffs};
    assign s_plus1    = NW'(found_slot) + NW'(1);
    assign next_head  = (s_plus1 >= n_cnt) ? '0 : s_plus1[XW-1:0];
    assign slot_bit   = map_rdata[r_slot[ROW_BW-1:0]];

    // Shared multiplier: slot times stride, or slot count times stride.
    assign mul_a    = (r_state == S_F_SUB) ? n_cnt : NW'(r_slot);
    assign mul_prod = PW'(mul_a) * PW'(r_slot_stride);

    assign sub_res = {1'b0, r_addr} - {1'b0, r_base_address};

    // Sequencer next state and map/divider controls.
    always_comb begin
        n_state   = r_state;
        map_we    = 1'b0;
        map_wdata = map_rdata;
        div_start = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                map_we    = 1'b1;
                map_wdata = '0;
                if (r_row == RIW'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_cmd == CMD_FREE) begin
                        n_state = S_F_SUB;
                    end else if (n_cnt == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (found) begin
                    map_we    = 1'b1;
                    map_wdata = map_rdata | (ROW_W'(1) << ffs);
                    n_state   = S_A_MUL;
                end else if (r_row != last_row) begin
                    n_state = S_RD;
                end else if (!r_pass && (r_start != '0)) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_A_MUL: begin
                n_state = S_A_ADD;
            end
            S_A_ADD: begin
                n_state = S_DONE;
            end
            S_F_SUB: begin
                n_state = S_F_CMP;
            end
            S_F_CMP: begin
                if (r_below) begin
                    n_state = S_DONE;
                end else if (r_slot_stride == '0) begin
                    n_state = ((r_offset == '0) && (n_cnt != '0)) ? S_F_RD : S_DONE;
                end else if (r_offset >= ADDR_W'(r_prod)) begin
                    n_state = S_DONE;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_F_DIV;
                end
            end
            S_F_DIV: begin
                if (div_stat.done) begin
                    n_state = S_F_RD;
                end
            end
            S_F_RD: begin
                n_state = S_F_CHK;
            end
            S_F_CHK: begin
                if (slot_bit) begin
                    map_we    = 1'b1;
                    map_wdata = map_rdata & ~(ROW_W'(1) << r_slot[ROW_BW-1:0]);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register, configuration and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_row          <= '0;
            r_pass         <= 1'b0;
            r_head         <= '0;
            r_out_valid    <= 1'b0;
            r_slots_in_use <= RST_SLOTS;
            r_base_address <= '0;
            r_slot_stride  <= RST_STRIDE;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SLOTS:  r_slots_in_use <= i_cfg_data[COUNT_W-1:0];
                    CFG_BASE:   r_base_address <= i_cfg_data;
                    CFG_STRIDE: r_slot_stride  <= i_cfg_data[STRIDE_W-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_CLEAR: begin
                    r_row <= (r_row == RIW'(ROWS - 1)) ? '0 : r_row + RIW'(1);
                end
                S_IDLE: begin
                    r_pass <= 1'b0;
                    r_row  <= start_slot[XW-1:ROW_BW];
                end
                S_CHK: begin
                    if (found) begin
                        r_head <= next_head;
                    end else if (r_row != last_row) begin
                        r_row <= r_row + RIW'(1);
                    end else begin
                        r_pass <= 1'b1;
                        r_row  <= '0;
                    end
                end
                S_F_CMP: begin
                    r_row <= '0;
                end
                S_F_DIV: begin
                    if (div_stat.done) begin
                        r_row <= div_quo[XW-1:ROW_BW];
                    end
                end
                default: ;
            endcase

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working payload and the result on its way out.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_addr       <= i_free_address;
                r_start      <= start_slot;
                r_lo         <= NW'(start_slot);
                r_hi         <= n_cnt;
                r_res_status <= ST_FULL;
                r_res_addr   <= '0;
                r_res_slot   <= '0;
            end
            S_CHK: begin
                if (found) begin
                    r_slot <= found_slot;
                end else if (r_row == last_row) begin
                    r_lo <= '0;
                    r_hi <= NW'(r_start);
                end
            end
            S_A_MUL: begin
                r_prod <= mul_prod;
            end
            S_A_ADD: begin
                r_res_status <= ST_OK;
                r_res_addr   <= r_base_address + ADDR_W'(r_prod);
                r_res_slot   <= r_slot;
            end
            S_F_SUB: begin
                r_offset     <= sub_res[ADDR_W-1:0];
                r_below      <= sub_res[ADDR_W];
                r_prod       <= mul_prod;
                r_res_status <= ST_RANGE;
            end
            S_F_CMP: begin
                r_slot <= '0;
            end
            S_F_DIV: begin
                if (div_stat.done) begin
                    r_slot <= div_quo;
                end
            end
            S_F_CHK: begin
                r_res_slot   <= r_slot;
                r_res_status <= slot_bit ? ST_OK : ST_DOUBLE;
            end
            default: ;
        endcase

        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_addr   <= r_res_addr;
            r_out_slot   <= slot_ext[SLOT_OUT_W-1:0];
        end
    end

    assign slot_ext = EW'(r_res_slot);

    rssa_map #(
        .ROWS (ROWS),
        .AW   (RIW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (r_row),
        .i_wdata (map_wdata),
        .i_raddr (r_row),
        .o_rdata (map_rdata)
    );

    rssa_div #(
        .QW (XW),
        .VW (STRIDE_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_offset[DW-1:0]),
        .i_divisor  (r_slot_stride),
        .o_quotient (div_quo),
        .o_stat     (div_stat)
    );

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_slot_address = r_out_addr;
    assign o_slot_number  = r_out_slot;

    // An accepted request keeps the input side stalled on the next cycle.
    `RSSA_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, i_in_valid && !o_in_stall,
                      o_in_stall)
    // Every map update outside the clearing pass flips exactly one slot.
    `RSSA_ASSERT_NOW(a_one_bit_update, i_clk, i_rst_n, map_we && (r_state != S_CLEAR),
                     $onehot(map_wdata ^ map_rdata))
    // While waiting on the divider it must be working or finishing.
    `RSSA_ASSERT_NOW(a_div_active, i_clk, i_rst_n, r_state == S_F_DIV,
                     div_stat.busy || div_stat.done)
    // The head always points inside the managed slots after an allocation.
    `RSSA_ASSERT_NOW(a_head_in_range, i_clk, i_rst_n, r_state == S_A_MUL,
                     NW'(r_head) < n_cnt)
    // Only a successful allocation carries a nonzero address.
    `RSSA_ASSERT_NOW(a_addr_only_ok, i_clk, i_rst_n, o_out_valid && (o_status != ST_OK),
                     o_slot_address == '0)

endmodule

`default_nettype wire

@@ dv/ring_scan_slot_allocator_test.sv @@
// Self-checking testbench for the ring scan slot allocator.
// Depends on rssa_pkg and ring_scan_slot_allocator; predicts every result beat
// and drives directed and random allocate/free traffic with random stalls.
`timescale 1ns / 1ps

module ring_scan_slot_allocator_test;
    import rssa_pkg::*;

    localparam int DEPTH         = 256;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 100;

    // Block ports; the inputs are at known values from time zero.
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_stall;
    logic                  i_cmd          = CMD_ALLOC;
    logic [ADDR_W-1:0]     i_free_address = '0;
    logic                  o_out_valid;
    logic                  i_out_stall    = 1'b0;
    logic [STATUS_W-1:0]   o_status;
    logic [ADDR_W-1:0]     o_slot_address;
    logic [SLOT_OUT_W-1:0] o_slot_number;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = CFG_SLOTS;
    logic [ADDR_W-1:0]     i_cfg_data     = '0;

    // Random idling on both channels is allowed while this is set.
    logic        idle_on     = 1'b1;
    int unsigned stall_left  = 0;
    int unsigned cycle_count = 0;

    // One result beat as the block should present it.
    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [ADDR_W-1:0]     addr;
        logic [SLOT_OUT_W-1:0] slot;
    } t_slot_grant;

    // Tracks the slot map and registers, and holds the grants still to arrive.
    class slot_ledger;
        bit                   taken [DEPTH];
        int unsigned          head;
        logic [COUNT_W-1:0]   cfg_slots;
        logic [ADDR_W-1:0]    cfg_base;
        logic [STRIDE_W-1:0]  cfg_stride;
        t_slot_grant          expected_grants[$];
        int unsigned          errors;

        function new();
            foreach (taken[i]) taken[i] = 1'b0;
            head       = 0;
            cfg_slots  = RST_SLOTS;
            cfg_base   = '0;
            cfg_stride = RST_STRIDE;
            errors     = 0;
        endfunction

        // Slots that take part: the programmed count, capped at the built depth.
        function int unsigned live_slots();
            return (cfg_slots > DEPTH) ? DEPTH : cfg_slots;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
            case (idx)
                CFG_SLOTS:  cfg_slots  = data[COUNT_W-1:0];
                CFG_BASE:   cfg_base   = data;
                CFG_STRIDE: cfg_stride = data[STRIDE_W-1:0];
                default: ;
            endcase
        endfunction

        // Works out the grant for one accepted request beat and queues it.
        function void note_request(logic cmd, logic [ADDR_W-1:0] addr);
            t_slot_grant     grant;
            int unsigned     n;
            int unsigned     start;
            int unsigned     s;
            int unsigned     k;
            longint unsigned offset;
            longint unsigned idx;
            bit              found;
            n     = live_slots();
            grant = '0;
            found = 1'b0;
            if (cmd == CMD_ALLOC) begin
                // Next-fit scan from the head, wrapping within the live slots.
                grant.status = ST_FULL;
                start = (head < n) ? head : 0;
                for (k = 0; k < n && !found; k++) begin
                    s = start + k;
                    if (s >= n) s -= n;
                    if (!taken[s]) begin
                        found        = 1'b1;
                        taken[s]     = 1'b1;
                        grant.status = ST_OK;
                        grant.addr   = cfg_base + s * cfg_stride;
                        grant.slot   = s[SLOT_OUT_W-1:0];
                        head         = (s + 1 >= n) ? 0 : s + 1;
                    end
                end
            end else if (addr < cfg_base) begin
                grant.status = ST_RANGE;
            end else begin
                // A zero stride only maps the base address itself, to slot zero.
                offset = addr - cfg_base;
                if (cfg_stride == 0)
                    idx = (offset == 0) ? 0 : n;
                else
                    idx = offset / cfg_stride;
                if (idx >= n) begin
                    grant.status = ST_RANGE;
                end else begin
                    grant.slot   = idx[SLOT_OUT_W-1:0];
                    grant.status = taken[idx] ? ST_OK : ST_DOUBLE;
                    taken[idx]   = 1'b0;
                end
            end
            expected_grants.push_back(grant);
        endfunction

        function void report(string field, longint unsigned want, longint unsigned got);
            errors++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
        endfunction

        // Compares one accepted result beat with the oldest outstanding grant.
        function void check_grant(logic [STATUS_W-1:0] status, logic [ADDR_W-1:0] addr,
                                  logic [SLOT_OUT_W-1:0] slot);
            t_slot_grant want;
            if (expected_grants.size() == 0) begin
                errors++;
                $display("%0t: result beat expected none, got status %0d addr 0x%0h slot %0d",
                         $time, status, addr, slot);
                return;
            end
            want = expected_grants.pop_front();
            if (status !== want.status) report("status", want.status, status);
            if (addr !== want.addr) report("slot_address", want.addr, addr);
            if (slot !== want.slot) report("slot_number", want.slot, slot);
        endfunction
    endclass

    slot_ledger ledger = new();

    ring_scan_slot_allocator #(
        .MAX_SLOTS(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_free_address (i_free_address),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_slot_address (o_slot_address),
        .o_slot_number  (o_slot_number),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Result side: check accepted beats and stall in random bursts.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            ledger.check_grant(o_status, o_slot_address, o_slot_number);
        if (!idle_on)
            stall_left = 0;
        else if (stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 11);
        i_out_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ring_scan_slot_allocator_test NOT OK");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    // Sends one request beat, after an optional idle burst, and waits for it to be taken.
    task automatic send_request(input logic cmd, input logic [ADDR_W-1:0] addr);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= cmd;
        i_free_address <= addr;
        do @(posedge i_clk); while (o_in_stall);
        ledger.note_request(cmd, addr);
    endtask

    task automatic post_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [ADDR_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        ledger.write_register(idx, data);
    endtask

    // Registers change only once every outstanding grant has come back.
    task automatic configure(input logic [COUNT_W-1:0] slots, input logic [ADDR_W-1:0] base,
                             input logic [STRIDE_W-1:0] stride);
        i_in_valid <= 1'b0;
        while (ledger.expected_grants.size() != 0) @(posedge i_clk);
        post_register(CFG_SLOTS, ADDR_W'(slots));
        post_register(CFG_BASE, base);
        post_register(CFG_STRIDE, ADDR_W'(stride));
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [COUNT_W-1:0]  slots;
        logic [STRIDE_W-1:0] stride;
        logic [ADDR_W-1:0]   base;
        logic [ADDR_W-1:0]   addr;
        int unsigned         phase;
        int unsigned         item;
        int unsigned         alloc_pct;
        int unsigned         n;
        int unsigned         start;
        int unsigned         s;
        int unsigned         k;
        int unsigned         kind;
        bit                  found;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default geometry: next-fit order, double free, rounding down, out of range.
        configure(9'd256, 48'h0, 13'd32);
        send_request(CMD_ALLOC, 48'hFFFF_FFFF_FFFF);
        send_request(CMD_ALLOC, 48'h0);
        send_request(CMD_FREE, 48'h0);
        send_request(CMD_FREE, 48'h0);
        send_request(CMD_FREE, 48'd37);
        send_request(CMD_FREE, 48'hFFFF_FFFF_FFFF);
        send_request(CMD_FREE, 48'd8192);

        // Three slots at the top of the address space with the widest stride:
        // the head starts mid-ring, addresses wrap and the ring fills up.
        configure(9'd3, 48'hFFFF_FFFF_FFF0, 13'h1FFF);
        repeat (4) send_request(CMD_ALLOC, 48'h0);
        send_request(CMD_FREE, 48'h0);
        send_request(CMD_FREE, 48'h0000_0000_1FF4);
        send_request(CMD_FREE, 48'hFFFF_FFFF_FFF0);

        // No slots at all.
        configure(9'd0, 48'h1000, 13'd16);
        send_request(CMD_ALLOC, 48'h0);
        send_request(CMD_FREE, 48'h1000);

        // Count above the built depth with a zero stride.
        configure(9'h1FF, 48'h1000, 13'd0);
        send_request(CMD_ALLOC, 48'h0);
        send_request(CMD_FREE, 48'h1000);
        send_request(CMD_FREE, 48'h1001);
        send_request(CMD_ALLOC, 48'h0);

        // Count lowered below the head: the scan restarts at slot zero.
        configure(9'd2, 48'h0, 13'd1);
        send_request(CMD_ALLOC, 48'h0);
        send_request(CMD_ALLOC, 48'h0);
        send_request(CMD_FREE, 48'h1);
        send_request(CMD_ALLOC, 48'h0);

        // Random phases, mostly small rings so they fill and wrap often.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: slots = COUNT_W'($urandom_range(1, 12));
                5, 6:          slots = COUNT_W'($urandom_range(13, 64));
                7:             slots = COUNT_W'(DEPTH);
                8:             slots = COUNT_W'($urandom_range(DEPTH + 1, 511));
                default:       slots = '0;
            endcase
            case ($urandom_range(0, 4))
                0:       base = '0;
                1:       base = 48'hFFFF_FFFF_FFFF - $urandom_range(0, 4096);
                default: base = rand_addr();
            endcase
            case ($urandom_range(0, 5))
                0:       stride = '0;
                1:       stride = 13'h1FFF;
                2:       stride = 13'd1;
                default: stride = STRIDE_W'($urandom_range(1, 4096));
            endcase
            configure(slots, base, stride);
            idle_on   <= (phase < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            alloc_pct = $urandom_range(30, 75);

            for (item = 0; item < PHASE_ITEMS; item++) begin
                n    = ledger.live_slots();
                addr = rand_addr();
                kind = $urandom_range(0, 9);
                if ($urandom_range(0, 99) < alloc_pct) begin
                    send_request(CMD_ALLOC, addr);
                end else begin
                    if (kind < 7 && n != 0) begin
                        // Free a slot that is in use, anywhere inside its span.
                        found = 1'b0;
                        start = $urandom_range(0, n - 1);
                        for (k = 0; k < n && !found; k++) begin
                            s = (start + k) % n;
                            if (ledger.taken[s]) found = 1'b1;
                        end
                        if (found)
                            addr = ledger.cfg_base + s * ledger.cfg_stride +
                                   ((ledger.cfg_stride != 0) ?
                                    $urandom_range(0, ledger.cfg_stride - 1) : 0);
                    end else if (kind == 8) begin
                        // Just below the base or just past the last slot.
                        if ($urandom_range(0, 1))
                            addr = ledger.cfg_base - $urandom_range(1, 1000);
                        else
                            addr = ledger.cfg_base + n * ledger.cfg_stride +
                                   $urandom_range(0, 3);
                    end else if (kind == 9 && n != 0) begin
                        // Slot boundary picked blindly, often a slot already free.
                        addr = ledger.cfg_base + $urandom_range(0, n - 1) * ledger.cfg_stride;
                    end
                    send_request(CMD_FREE, addr);
                end
            end
        end

        // Drain the outstanding grants, then watch for stray result beats.
        i_in_valid <= 1'b0;
        while (ledger.expected_grants.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (ledger.errors == 0 && ledger.expected_grants.size() == 0)
            $display("ring_scan_slot_allocator_test OK");
        else
            $display("ring_scan_slot_allocator_test NOT OK");
        $finish;
    end

endmodule
